/* design/rv32x_pkg.sv */
// ----------------------------------------------------------------------------
// RV32 subset execute package
// Shared widths, opcodes, function codes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rv32x_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned DATA_MEM_BYTES_DEF = 4096;
  localparam logic [31:0] START_PC_RST = 32'h8000_0000;

  // Major opcodes.
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

  localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;

  // Function 7 codes of register operations.
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;
  localparam logic [6:0] F7_MULDIV = 7'b0000001;
  localparam logic [5:0] F6_SRA  = 6'b010000;

  // Function 3 codes.
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;
  localparam logic [2:0] F3_LH   = 3'd1;
  localparam logic [2:0] F3_LW   = 3'd2;
  localparam logic [2:0] F3_LBU  = 3'd4;
  localparam logic [2:0] F3_SB   = 3'd0;
  localparam logic [2:0] F3_SW   = 3'd2;
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_MUL  = 3'd0;
  localparam logic [2:0] F3_MULH = 3'd1;
  localparam logic [2:0] F3_DIV  = 3'd4;
  localparam logic [2:0] F3_DIVU = 3'd5;
  localparam logic [2:0] F3_REM  = 3'd6;
  localparam logic [2:0] F3_REMU = 3'd7;

  // Result status codes.
  localparam logic [1:0] ST_EXEC    = 2'd0;
  localparam logic [1:0] ST_EBREAK  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic [4:0] REG_A0 = 5'd10;

endpackage

`default_nettype wire

/* design/rv32x_div.sv */
// ----------------------------------------------------------------------------
// RV32 subset shared divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32x_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rv32x_pkg::XLEN-1:0]  dividend_i,
  input  wire logic [rv32x_pkg::XLEN-1:0]  divisor_i,
  output logic                             done_o,
  output logic [rv32x_pkg::XLEN-1:0]       quotient_o,
  output logic [rv32x_pkg::XLEN-1:0]       remainder_o
);

  localparam int unsigned W = rv32x_pkg::XLEN;
  localparam int unsigned CW = $clog2(W);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  quo_q;
  logic [W-1:0]  rem_q;
  logic [W-1:0]  dvs_q;
  logic [W:0]    trial;
  logic [W+1:0]  diff;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};

  // Control and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        if (!diff[W+1]) begin
          rem_q <= diff[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b1};
        end else begin
          rem_q <= trial[W-1:0];
          quo_q <= {quo_q[W-2:0], 1'b0};
        end
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

/* design/rv32_subset_instruction_execute_top.sv */
// ALU, jump and branch items pass through read, execute and done states; mul and
// mulh add a multiply state, division waits on the shared divider, and each memory
// byte takes an index step and a read and capture or a write (the index goes through
// the divider when the memory size is not a power of two). One item at a time: the
// next item is taken once the result sits in the output register. After reset the
// data memory is cleared byte by byte, during which no item is accepted.
// ----------------------------------------------------------------------------
// RV32 subset instruction execute
// Multicycle executor of an RV32IM subset with register file, byte data
// memory and a shared iterative divider under a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32_subset_instruction_execute_top #(
  parameter int unsigned DATA_MEM_BYTES = rv32x_pkg::DATA_MEM_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] instruction_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      exec_pc_o,
  output logic [31:0]      next_pc_o,
  output logic [4:0]       dest_index_o,
  output logic [31:0]      dest_value_o,
  output logic             dest_written_o,
  output logic             store_done_o,
  output logic [31:0]      access_addr_o,
  output logic [1:0]       status_o,
  output logic [31:0]      halt_code_o
);

  localparam int unsigned AW = $clog2(DATA_MEM_BYTES);
  localparam logic [AW-1:0] MEM_LAST = AW'(DATA_MEM_BYTES - 1);
  localparam bit MEM_POW2 = (DATA_MEM_BYTES == (1 << AW));
  localparam logic [31:0] MEM_SIZE = 32'(DATA_MEM_BYTES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV_WT, S_MEM_IDX, S_MOD_WT,
    S_MEM_RD, S_MEM_CAP, S_MEM_WR, S_DONE
  } state_e;

  typedef enum logic [2:0] {
    K_ALU, K_MUL, K_DIV, K_LOAD, K_STORE
  } kind_e;

  state_e state_q;
  kind_e  kind_q;
  kind_e  ex_kind;

  // Architectural state.
  logic [31:0]   pc_q;
  logic          halted_q;
  logic [31:0]   rf_q [32];
  logic [31:0]   rf_valid_q;
  logic [7:0]    dmem [DATA_MEM_BYTES];
  logic [AW-1:0] clr_q;

  // Item in flight.
  logic [31:0]   ins_q;
  logic [31:0]   a_q;
  logic [31:0]   b_q;
  logic [31:0]   a0_q;
  logic [63:0]   mul_q;
  logic [31:0]   res_npc_q;
  logic [31:0]   res_val_q;
  logic [31:0]   res_addr_q;
  logic [1:0]    res_status_q;
  logic          res_wr_q;
  logic          res_st_q;
  logic [1:0]    nb_m1_q;
  logic [1:0]    k_q;
  logic [31:0]   ld_q;
  logic [AW-1:0] idx_q;
  logic [7:0]    dmem_q;

  // Output register.
  logic        out_valid_q;
  logic [31:0] out_pc_q;
  logic [31:0] out_npc_q;
  logic [4:0]  out_rd_q;
  logic [31:0] out_val_q;
  logic        out_wr_q;
  logic        out_st_q;
  logic [31:0] out_addr_q;
  logic [1:0]  out_status_q;
  logic [31:0] out_code_q;

  // Instruction fields.
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [31:0] immi;
  logic [31:0] imms;
  logic [31:0] immb;
  logic [31:0] immj;
  logic [31:0] immu;
  logic [31:0] pc_plus4;

  assign opc  = ins_q[6:0];
  assign f3   = ins_q[14:12];
  assign f7   = ins_q[31:25];
  assign rd   = ins_q[11:7];
  assign rs1  = ins_q[19:15];
  assign rs2  = ins_q[24:20];
  assign immi = {{20{ins_q[31]}}, ins_q[31:20]};
  assign imms = {{20{ins_q[31]}}, ins_q[31:25], ins_q[11:7]};
  assign immb = {{19{ins_q[31]}}, ins_q[31], ins_q[7], ins_q[30:25], ins_q[11:8], 1'b0};
  assign immj = {{11{ins_q[31]}}, ins_q[31], ins_q[19:12], ins_q[20], ins_q[30:21], 1'b0};
  assign immu = {ins_q[31:12], 12'h000};
  assign pc_plus4 = pc_q + 32'd4;

  // Decode and combinational execution of the operands held in a_q and b_q.
  logic        ex_bad;
  logic        ex_halt;
  logic        ex_wr;
  logic        ex_st;
  logic        br_take;
  logic [31:0] ex_val;
  logic [31:0] ex_npc;
  logic [31:0] ex_addr;
  logic [1:0]  ex_nb_m1;

  always_comb begin
    ex_kind  = K_ALU;
    ex_bad   = 1'b0;
    ex_halt  = 1'b0;
    ex_wr    = 1'b0;
    ex_st    = 1'b0;
    br_take  = 1'b0;
    ex_val   = '0;
    ex_npc   = pc_plus4;
    ex_addr  = '0;
    ex_nb_m1 = 2'd0;
    case (opc)
      rv32x_pkg::OPC_LUI: begin
        ex_wr  = 1'b1;
        ex_val = immu;
      end
      rv32x_pkg::OPC_AUIPC: begin
        ex_wr  = 1'b1;
        ex_val = pc_q + immu;
      end
      rv32x_pkg::OPC_JAL: begin
        ex_wr  = 1'b1;
        ex_val = pc_plus4;
        ex_npc = pc_q + immj;
      end
      rv32x_pkg::OPC_JALR: begin
        if (f3 != 3'd0) begin
          ex_bad = 1'b1;
        end else begin
          ex_wr  = 1'b1;
          ex_val = pc_plus4;
          ex_npc = (a_q + immi) & ~32'd1;
        end
      end
      rv32x_pkg::OPC_BRANCH: begin
        case (f3)
          rv32x_pkg::F3_BEQ:  br_take = (a_q == b_q);
          rv32x_pkg::F3_BNE:  br_take = (a_q != b_q);
          rv32x_pkg::F3_BLT:  br_take = ($signed(a_q) < $signed(b_q));
          rv32x_pkg::F3_BGE:  br_take = !($signed(a_q) < $signed(b_q));
          rv32x_pkg::F3_BLTU: br_take = (a_q < b_q);
          rv32x_pkg::F3_BGEU: br_take = (a_q >= b_q);
          default:            ex_bad  = 1'b1;
        endcase
        if (br_take) begin
          ex_npc = pc_q + immb;
        end
      end
      rv32x_pkg::OPC_LOAD: begin
        ex_kind = K_LOAD;
        ex_wr   = 1'b1;
        ex_addr = a_q + immi;
        case (f3)
          rv32x_pkg::F3_LBU: ex_nb_m1 = 2'd0;
          rv32x_pkg::F3_LH:  ex_nb_m1 = 2'd1;
          rv32x_pkg::F3_LW:  ex_nb_m1 = 2'd3;
          default:           ex_bad   = 1'b1;
        endcase
      end
      rv32x_pkg::OPC_STORE: begin
        ex_kind = K_STORE;
        ex_st   = 1'b1;
        ex_addr = a_q + imms;
        case (f3)
          rv32x_pkg::F3_SB: ex_nb_m1 = 2'd0;
          rv32x_pkg::F3_SW: ex_nb_m1 = 2'd3;
          default:          ex_bad   = 1'b1;
        endcase
      end
      rv32x_pkg::OPC_OPIMM: begin
        ex_wr = 1'b1;
        case (f3)
          rv32x_pkg::F3_ADD:  ex_val = a_q + immi;
          rv32x_pkg::F3_SLTU: ex_val = {31'd0, (a_q < immi)};
          rv32x_pkg::F3_AND:  ex_val = a_q & immi;
          rv32x_pkg::F3_XOR:  ex_val = a_q ^ immi;
          rv32x_pkg::F3_SLL: begin
            if (f7[6:1] != 6'd0) ex_bad = 1'b1;
            else ex_val = a_q << rs2;
          end
          rv32x_pkg::F3_SR: begin
            if (f7[6:1] == 6'd0) ex_val = a_q >> rs2;
            else if (f7[6:1] == rv32x_pkg::F6_SRA) ex_val = 32'($signed(a_q) >>> rs2);
            else ex_bad = 1'b1;
          end
          default: ex_bad = 1'b1;
        endcase
      end
      rv32x_pkg::OPC_OP: begin
        ex_wr = 1'b1;
        case (f7)
          rv32x_pkg::F7_BASE: begin
            case (f3)
              rv32x_pkg::F3_ADD:  ex_val = a_q + b_q;
              rv32x_pkg::F3_SLT:  ex_val = {31'd0, ($signed(a_q) < $signed(b_q))};
              rv32x_pkg::F3_SLTU: ex_val = {31'd0, (a_q < b_q)};
              rv32x_pkg::F3_XOR:  ex_val = a_q ^ b_q;
              rv32x_pkg::F3_OR:   ex_val = a_q | b_q;
              rv32x_pkg::F3_SR:   ex_val = a_q >> b_q[4:0];
              default:            ex_bad = 1'b1;
            endcase
          end
          rv32x_pkg::F7_ALT: begin
            if (f3 == rv32x_pkg::F3_ADD) ex_val = a_q - b_q;
            else if (f3 == rv32x_pkg::F3_SR) ex_val = 32'($signed(a_q) >>> b_q[4:0]);
            else ex_bad = 1'b1;
          end
          rv32x_pkg::F7_MULDIV: begin
            case (f3)
              rv32x_pkg::F3_MUL, rv32x_pkg::F3_MULH: ex_kind = K_MUL;
              rv32x_pkg::F3_DIV, rv32x_pkg::F3_DIVU,
              rv32x_pkg::F3_REM, rv32x_pkg::F3_REMU: ex_kind = K_DIV;
              default: ex_bad = 1'b1;
            endcase
          end
          default: ex_bad = 1'b1;
        endcase
      end
      rv32x_pkg::OPC_SYSTEM: begin
        if (ins_q == rv32x_pkg::INSN_EBREAK) ex_halt = 1'b1;
        else ex_bad = 1'b1;
      end
      default: ex_bad = 1'b1;
    endcase
    // An invalid encoding writes no register or memory and moves the pc on by one word.
    if (ex_bad) begin
      ex_kind = K_ALU;
      ex_wr   = 1'b0;
      ex_st   = 1'b0;
      ex_addr = '0;
      ex_npc  = pc_plus4;
    end
  end

  // Multiplier: signed 33 by 33 product covers both mul and mulh.
  logic signed [65:0] prod;
  assign prod = $signed({a_q[31], a_q}) * $signed({b_q[31], b_q});

  // Shared divider: division, signed ones on magnitudes, or byte address reduction.
  logic        div_start;
  logic        div_done;
  logic [31:0] div_dividend;
  logic [31:0] div_divisor;
  logic [31:0] div_quo;
  logic [31:0] div_rem;
  logic        div_signed;
  logic [31:0] a_mag;
  logic [31:0] b_mag;
  logic [31:0] byte_addr;

  assign div_signed = (f3 == rv32x_pkg::F3_DIV) || (f3 == rv32x_pkg::F3_REM);
  assign a_mag      = (div_signed && a_q[31]) ? (32'd0 - a_q) : a_q;
  assign b_mag      = (div_signed && b_q[31]) ? (32'd0 - b_q) : b_q;
  assign byte_addr  = res_addr_q + 32'(k_q);

  assign div_start = ((state_q == S_EXEC) && (ex_kind == K_DIV)) ||
                     ((state_q == S_MEM_IDX) && !MEM_POW2);
  assign div_dividend = (state_q == S_EXEC) ? a_mag : byte_addr;
  assign div_divisor  = (state_q == S_EXEC) ? b_mag : MEM_SIZE;

  rv32x_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Division result with the sign and divide-by-zero rules applied.
  logic [31:0] div_val;
  always_comb begin
    case (f3)
      rv32x_pkg::F3_DIV: begin
        if (b_q == 32'd0) div_val = '1;
        else if (a_q[31] ^ b_q[31]) div_val = 32'd0 - div_quo;
        else div_val = div_quo;
      end
      rv32x_pkg::F3_REM: begin
        if (b_q == 32'd0) div_val = a_q;
        else if (a_q[31]) div_val = 32'd0 - div_rem;
        else div_val = div_rem;
      end
      rv32x_pkg::F3_DIVU: div_val = div_quo;
      default:            div_val = div_rem;
    endcase
  end

  // Retirement: final value and whether it reaches the register file.
  logic        out_free;
  logic        wr_eff;
  logic [31:0] fin_val;
  logic        is_halt;

  assign out_free = !out_valid_q || !out_stall_i;
  assign wr_eff   = res_wr_q && (rd != 5'd0);
  assign is_halt  = (res_status_q == rv32x_pkg::ST_EBREAK) ||
                    (res_status_q == rv32x_pkg::ST_INVALID);
  always_comb begin
    if (kind_q == K_LOAD) begin
      if (f3 == rv32x_pkg::F3_LH) fin_val = {{16{ld_q[15]}}, ld_q[15:0]};
      else fin_val = ld_q;
    end else begin
      fin_val = res_val_q;
    end
  end

  // Sequencer with its registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      kind_q       <= K_ALU;
      pc_q         <= rv32x_pkg::START_PC_RST;
      halted_q     <= 1'b0;
      clr_q        <= '0;
      ins_q        <= '0;
      mul_q        <= '0;
      res_npc_q    <= '0;
      res_val_q    <= '0;
      res_addr_q   <= '0;
      res_status_q <= rv32x_pkg::ST_EXEC;
      res_wr_q     <= 1'b0;
      res_st_q     <= 1'b0;
      nb_m1_q      <= '0;
      k_q          <= '0;
      ld_q         <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      out_pc_q     <= '0;
      out_npc_q    <= '0;
      out_rd_q     <= '0;
      out_val_q    <= '0;
      out_wr_q     <= 1'b0;
      out_st_q     <= 1'b0;
      out_addr_q   <= '0;
      out_status_q <= rv32x_pkg::ST_EXEC;
      out_code_q   <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == MEM_LAST) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            ins_q <= instruction_i;
            if (halted_q) begin
              // Halted: the item is reported and otherwise ignored.
              kind_q       <= K_ALU;
              res_npc_q    <= pc_q;
              res_val_q    <= '0;
              res_addr_q   <= '0;
              res_status_q <= rv32x_pkg::ST_IGNORED;
              res_wr_q     <= 1'b0;
              res_st_q     <= 1'b0;
              state_q      <= S_DONE;
            end else begin
              state_q <= S_READ;
            end
          end
        end
        S_READ: state_q <= S_EXEC;
        S_EXEC: begin
          kind_q     <= ex_kind;
          res_npc_q  <= ex_npc;
          res_val_q  <= ex_val;
          res_addr_q <= ex_addr;
          res_wr_q   <= ex_wr;
          res_st_q   <= ex_st;
          nb_m1_q    <= ex_nb_m1;
          k_q        <= '0;
          ld_q       <= '0;
          mul_q      <= prod[63:0];
          if (ex_bad) res_status_q <= rv32x_pkg::ST_INVALID;
          else if (ex_halt) res_status_q <= rv32x_pkg::ST_EBREAK;
          else res_status_q <= rv32x_pkg::ST_EXEC;
          case (ex_kind)
            K_MUL:            state_q <= S_MUL;
            K_DIV:            state_q <= S_DIV_WT;
            K_LOAD, K_STORE:  state_q <= S_MEM_IDX;
            default:          state_q <= S_DONE;
          endcase
        end
        S_MUL: begin
          res_val_q <= (f3 == rv32x_pkg::F3_MULH) ? mul_q[63:32] : mul_q[31:0];
          state_q   <= S_DONE;
        end
        S_DIV_WT: begin
          if (div_done) begin
            res_val_q <= div_val;
            state_q   <= S_DONE;
          end
        end
        S_MEM_IDX: begin
          if (MEM_POW2) begin
            idx_q   <= byte_addr[AW-1:0];
            state_q <= (kind_q == K_LOAD) ? S_MEM_RD : S_MEM_WR;
          end else begin
            state_q <= S_MOD_WT;
          end
        end
        S_MOD_WT: begin
          if (div_done) begin
            idx_q   <= div_rem[AW-1:0];
            state_q <= (kind_q == K_LOAD) ? S_MEM_RD : S_MEM_WR;
          end
        end
        S_MEM_RD: state_q <= S_MEM_CAP;
        S_MEM_CAP: begin
          ld_q[{k_q, 3'b000} +: 8] <= dmem_q;
          k_q <= k_q + 1'b1;
          state_q <= (k_q == nb_m1_q) ? S_DONE : S_MEM_IDX;
        end
        S_MEM_WR: begin
          k_q <= k_q + 1'b1;
          state_q <= (k_q == nb_m1_q) ? S_DONE : S_MEM_IDX;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_pc_q     <= pc_q;
            out_npc_q    <= res_npc_q;
            out_rd_q     <= wr_eff ? rd : 5'd0;
            out_val_q    <= wr_eff ? fin_val : 32'd0;
            out_wr_q     <= wr_eff;
            out_st_q     <= res_st_q;
            out_addr_q   <= res_addr_q;
            out_status_q <= res_status_q;
            out_code_q   <= is_halt ? a0_q : 32'd0;
            pc_q         <= res_npc_q;
            if (is_halt) halted_q <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // Writing start_pc also loads the program counter.
      if (cfg_we_i) begin
        pc_q <= cfg_wdata_i;
      end
    end
  end

  // Register file: valid bits stand in for the reset to zero.
  logic rf_we;
  assign rf_we = (state_q == S_DONE) && out_free && wr_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q <= '0;
    end else if (rf_we) begin
      rf_valid_q[rd] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_q[rd] <= fin_val;
    end
    if (state_q == S_READ) begin
      a_q <= rf_valid_q[rs1] ? rf_q[rs1] : 32'd0;
      b_q <= rf_valid_q[rs2] ? rf_q[rs2] : 32'd0;
    end
    if (state_q == S_EXEC) begin
      a0_q <= rf_valid_q[rv32x_pkg::REG_A0] ? rf_q[rv32x_pkg::REG_A0] : 32'd0;
    end
  end

  // Data memory: cleared after reset, then read or written one byte at a time.
  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      dmem[clr_q] <= 8'h00;
    end else if (state_q == S_MEM_WR) begin
      dmem[idx_q] <= b_q[{k_q, 3'b000} +: 8];
    end
    if (state_q == S_MEM_RD) begin
      dmem_q <= dmem[idx_q];
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign exec_pc_o      = out_pc_q;
  assign next_pc_o      = out_npc_q;
  assign dest_index_o   = out_rd_q;
  assign dest_value_o   = out_val_q;
  assign dest_written_o = out_wr_q;
  assign store_done_o   = out_st_q;
  assign access_addr_o  = out_addr_q;
  assign status_o       = out_status_q;
  assign halt_code_o    = out_code_q;

endmodule

`default_nettype wire

/* design/rv32x_chk.sv */
// ----------------------------------------------------------------------------
// RV32 subset execute port checker
// Checks result items on the top level's ports over time.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32x_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] exec_pc_o,
  input wire logic [31:0] next_pc_o,
  input wire logic [4:0]  dest_index_o,
  input wire logic        dest_written_o,
  input wire logic        store_done_o,
  input wire logic [1:0]  status_o
);

  // A stalled item stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // An ignored item leaves the pc where it was and writes nothing.
  a_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == rv32x_pkg::ST_IGNORED) |->
      (exec_pc_o == next_pc_o) && !dest_written_o && !store_done_o)
    else $error("ignored item changed state");

  // A reported write never names x0.
  a_no_x0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dest_written_o |-> (dest_index_o != 5'd0))
    else $error("write to x0 reported");

  // A halting item writes neither register nor memory.
  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == rv32x_pkg::ST_EBREAK) ||
                    (status_o == rv32x_pkg::ST_INVALID)) |->
      !dest_written_o && !store_done_o)
    else $error("halting item wrote state");

  // A store never also writes a register.
  a_store_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_done_o |-> !dest_written_o)
    else $error("store item reported a register write");

endmodule

bind rv32_subset_instruction_execute_top rv32x_chk u_rv32x_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .exec_pc_o      (exec_pc_o),
  .next_pc_o      (next_pc_o),
  .dest_index_o   (dest_index_o),
  .dest_written_o (dest_written_o),
  .store_done_o   (store_done_o),
  .status_o       (status_o)
);

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// RV32 subset instruction execute testbench
// Feeds instruction words through the valid/stall input channel, predicts
// each result from a behavioural copy of the pc, register file and data
// memory, and compares every returned result field by field. A short
// directed table comes first, then random well-formed programs over several
// start pc settings, and finally a halt followed by ignored items.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rv32x_pkg::*;

  localparam int unsigned MEM_BYTES = 4096;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned RAND_PER_PHASE = 430;
  localparam int unsigned SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [31:0] exec_pc;
    logic [31:0] next_pc;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        dest_written;
    logic        store_done;
    logic [31:0] access_addr;
    logic [1:0]  status;
    logic [31:0] halt_code;
  } exec_res_t;

  typedef struct {
    logic [31:0] insn;
    bit          typed;
    exec_res_t   res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] instruction;
  logic        out_valid;
  logic        out_stall;
  exec_res_t   dut_res;

  // Predictor state.
  logic [31:0] model_pc;
  logic [31:0] rf [32];
  logic [7:0]  dmem [MEM_BYTES];
  logic        model_halted;

  exec_res_t   expected_q [$];
  dir_row_t    dir_rows [$];
  exec_res_t   got_res;
  exec_res_t   want_res;
  int unsigned mismatches;
  int unsigned cycle_cnt;
  int unsigned items_sent;

  rv32_subset_instruction_execute_top #(
    .DATA_MEM_BYTES(MEM_BYTES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .instruction_i (instruction),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .exec_pc_o     (dut_res.exec_pc),
    .next_pc_o     (dut_res.next_pc),
    .dest_index_o  (dut_res.dest_index),
    .dest_value_o  (dut_res.dest_value),
    .dest_written_o(dut_res.dest_written),
    .store_done_o  (dut_res.store_done),
    .access_addr_o (dut_res.access_addr),
    .status_o      (dut_res.status),
    .halt_code_o   (dut_res.halt_code)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Instruction encoders.
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
  endfunction

  function automatic exec_res_t alu_res(logic [31:0] pc, logic [4:0] rd, logic [31:0] val);
    exec_res_t r;
    r = '0;
    r.exec_pc = pc;
    r.next_pc = pc + 32'd4;
    r.dest_index = rd;
    r.dest_value = val;
    r.dest_written = 1'b1;
    return r;
  endfunction

  // Executes one instruction on the behavioural state and returns its result.
  task automatic predict_exec(input logic [31:0] ins, output exec_res_t r);
    logic [6:0]  opc;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] a, b, immi, imms, immb, immj, immu;
    logic [31:0] pc, npc, val, addr, ea;
    logic [1:0]  st_code;
    logic        wr, stv, bad, take;
    logic signed [63:0] pa, pb, prod;
    int          nbytes;
    r = '0;
    pc = model_pc;
    if (model_halted) begin
      r.exec_pc = pc;
      r.next_pc = pc;
      r.status = ST_IGNORED;
      return;
    end
    opc = ins[6:0];
    f3 = ins[14:12];
    f7 = ins[31:25];
    rd = ins[11:7];
    a = rf[ins[19:15]];
    b = rf[ins[24:20]];
    immi = {{20{ins[31]}}, ins[31:20]};
    imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    immu = {ins[31:12], 12'b0};
    npc = pc + 32'd4;
    val = '0;
    addr = '0;
    st_code = ST_EXEC;
    wr = 1'b0;
    stv = 1'b0;
    bad = 1'b0;
    take = 1'b0;
    case (opc)
      OPC_LUI: begin
        val = immu;
        wr = 1'b1;
      end
      OPC_AUIPC: begin
        val = pc + immu;
        wr = 1'b1;
      end
      OPC_JAL: begin
        val = npc;
        wr = 1'b1;
        npc = pc + immj;
      end
      OPC_JALR: begin
        if (f3 != 3'd0) begin
          bad = 1'b1;
        end else begin
          val = npc;
          wr = 1'b1;
          npc = (a + immi) & ~32'd1;
        end
      end
      OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  take = (a == b);
          F3_BNE:  take = (a != b);
          F3_BLT:  take = ($signed(a) < $signed(b));
          F3_BGE:  take = !($signed(a) < $signed(b));
          F3_BLTU: take = (a < b);
          F3_BGEU: take = (a >= b);
          default: bad = 1'b1;
        endcase
        if (take) npc = pc + immb;
      end
      OPC_LOAD: begin
        addr = a + immi;
        case (f3)
          F3_LBU:  nbytes = 1;
          F3_LH:   nbytes = 2;
          F3_LW:   nbytes = 4;
          default: begin
            nbytes = 0;
            bad = 1'b1;
          end
        endcase
        for (int k = 0; k < nbytes; k++) begin
          ea = addr + k;
          val[8*k +: 8] = dmem[ea[11:0]];
        end
        if (f3 == F3_LH) val = {{16{val[15]}}, val[15:0]};
        wr = !bad;
      end
      OPC_STORE: begin
        addr = a + imms;
        case (f3)
          F3_SB:   nbytes = 1;
          F3_SW:   nbytes = 4;
          default: begin
            nbytes = 0;
            bad = 1'b1;
          end
        endcase
        for (int k = 0; k < nbytes; k++) begin
          ea = addr + k;
          dmem[ea[11:0]] = b[8*k +: 8];
        end
        stv = !bad;
      end
      OPC_OPIMM: begin
        wr = 1'b1;
        case (f3)
          F3_ADD:  val = a + immi;
          F3_SLTU: val = (a < immi) ? 32'd1 : 32'd0;
          F3_AND:  val = a & immi;
          F3_XOR:  val = a ^ immi;
          F3_SLL: begin
            if (f7[6:1] != 6'd0) bad = 1'b1;
            else val = a << immi[4:0];
          end
          F3_SR: begin
            if (f7[6:1] == 6'd0) val = a >> immi[4:0];
            else if (f7[6:1] == F6_SRA) val = $signed(a) >>> immi[4:0];
            else bad = 1'b1;
          end
          default: bad = 1'b1;
        endcase
      end
      OPC_OP: begin
        wr = 1'b1;
        if (f7 == F7_BASE) begin
          case (f3)
            F3_ADD:  val = a + b;
            F3_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_SLTU: val = (a < b) ? 32'd1 : 32'd0;
            F3_XOR:  val = a ^ b;
            F3_OR:   val = a | b;
            F3_SR:   val = a >> b[4:0];
            default: bad = 1'b1;
          endcase
        end else if (f7 == F7_ALT) begin
          if (f3 == F3_ADD) val = a - b;
          else if (f3 == F3_SR) val = $signed(a) >>> b[4:0];
          else bad = 1'b1;
        end else if (f7 == F7_MULDIV) begin
          case (f3)
            F3_MUL: val = a * b;
            F3_MULH: begin
              pa = $signed(a);
              pb = $signed(b);
              prod = pa * pb;
              val = prod[63:32];
            end
            F3_DIV: begin
              if (b == 32'd0) val = '1;
              else if (a == 32'h8000_0000 && b == '1) val = 32'h8000_0000;
              else val = $signed(a) / $signed(b);
            end
            F3_DIVU: val = (b == 32'd0) ? '1 : a / b;
            F3_REM: begin
              if (b == 32'd0) val = a;
              else if (a == 32'h8000_0000 && b == '1) val = 32'd0;
              else val = $signed(a) % $signed(b);
            end
            F3_REMU: val = (b == 32'd0) ? a : a % b;
            default: bad = 1'b1;
          endcase
        end else begin
          bad = 1'b1;
        end
      end
      OPC_SYSTEM: begin
        if (ins == INSN_EBREAK) st_code = ST_EBREAK;
        else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase

    // An invalid encoding cancels every side effect and halts.
    if (bad) begin
      st_code = ST_INVALID;
      wr = 1'b0;
      stv = 1'b0;
      addr = '0;
      npc = pc + 32'd4;
    end
    if (st_code != ST_EXEC) begin
      model_halted = 1'b1;
      r.halt_code = rf[REG_A0];
    end
    if (wr && rd != 5'd0) begin
      rf[rd] = val;
      r.dest_index = rd;
      r.dest_value = val;
      r.dest_written = 1'b1;
    end
    model_pc = npc;
    r.exec_pc = pc;
    r.next_pc = npc;
    r.store_done = stv;
    r.access_addr = addr;
    r.status = st_code;
  endtask

  // Register picks lean towards a few low registers so that results get reused.
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
  endfunction

  // Random well-formed instruction of the supported subset.
  function automatic logic [31:0] rand_insn();
    logic [2:0]  opimm_f3 [6] = '{F3_ADD, F3_SLTU, F3_AND, F3_XOR, F3_SLL, F3_SR};
    logic [2:0]  base_f3  [6] = '{F3_ADD, F3_SLT, F3_SLTU, F3_XOR, F3_OR, F3_SR};
    logic [2:0]  md_f3    [6] = '{F3_MUL, F3_MULH, F3_DIV, F3_DIVU, F3_REM, F3_REMU};
    logic [2:0]  br_f3    [6] = '{F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU};
    logic [2:0]  ld_f3    [3] = '{F3_LBU, F3_LH, F3_LW};
    logic [2:0]  f3;
    logic [11:0] imm;
    logic [4:0]  rs1;
    int unsigned cat;
    cat = $urandom_range(0, 99);
    imm = 12'($urandom);
    if (cat < 22) begin
      f3 = opimm_f3[$urandom_range(0, 5)];
      if (f3 == F3_SLL) imm = {6'd0, imm[5:0]};
      if (f3 == F3_SR) imm = {($urandom_range(0, 1) == 0) ? 6'd0 : F6_SRA, imm[5:0]};
      return enc_i(imm, pick_reg(), f3, 5'($urandom), OPC_OPIMM);
    end else if (cat < 40) begin
      if ($urandom_range(0, 3) == 0) begin
        f3 = ($urandom_range(0, 1) == 0) ? F3_ADD : F3_SR;
        return enc_r(F7_ALT, pick_reg(), pick_reg(), f3, 5'($urandom), OPC_OP);
      end
      f3 = base_f3[$urandom_range(0, 5)];
      return enc_r(F7_BASE, pick_reg(), pick_reg(), f3, 5'($urandom), OPC_OP);
    end else if (cat < 50) begin
      f3 = md_f3[$urandom_range(0, 5)];
      return enc_r(F7_MULDIV, pick_reg(), pick_reg(), f3, 5'($urandom), OPC_OP);
    end else if (cat < 70) begin
      // Memory accesses: half of them in a small window so that loads meet stores.
      rs1 = pick_reg();
      if ($urandom_range(0, 1) == 0) begin
        rs1 = 5'd0;
        imm = 12'($urandom_range(0, 40));
      end
      if (cat < 60)
        return enc_i(imm, rs1, ld_f3[$urandom_range(0, 2)], 5'($urandom), OPC_LOAD);
      return enc_s(imm, pick_reg(), rs1, ($urandom_range(0, 1) == 0) ? F3_SB : F3_SW);
    end else if (cat < 82) begin
      return enc_b(13'($urandom), pick_reg(), pick_reg(), br_f3[$urandom_range(0, 5)]);
    end else if (cat < 90) begin
      return {20'($urandom), 5'($urandom),
              ($urandom_range(0, 1) == 0) ? OPC_LUI : OPC_AUIPC};
    end else if (cat < 95) begin
      return enc_j(21'($urandom), 5'($urandom));
    end
    return enc_i(imm, pick_reg(), 3'd0, 5'($urandom), OPC_JALR);
  endfunction

  // Sends one item, holding valid across back-to-back items but for random gaps.
  task automatic send_item(input logic [31:0] ins, input bit typed, input exec_res_t typed_res);
    exec_res_t r;
    predict_exec(ins, r);
    expected_q.push_back(typed ? typed_res : r);
    if (!(items_sent >= 700 && items_sent < 1000) && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    instruction <= ins;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Writes start_pc once the block has drained and settled.
  task automatic write_start_pc(input logic [31:0] value);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    model_pc = value;
  endtask

  task automatic add_row(input logic [31:0] ins, input bit typed, input exec_res_t res);
    dir_row_t row;
    row.insn = ins;
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endtask

  // Directed table: extremes, every operation and the special cases.
  task automatic build_table();
    exec_res_t none;
    none = '0;
    add_row(enc_u_lui(20'hFFFFF, 5'd1), 1'b1, alu_res(32'd0, 5'd1, 32'hFFFF_F000));
    add_row(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd2, OPC_OPIMM), 1'b1,
            alu_res(32'd4, 5'd2, 32'hFFFF_FFFF));
    add_row(enc_r(F7_MULDIV, 5'd0, 5'd1, F3_DIVU, 5'd3, OPC_OP), 1'b1,
            alu_res(32'd8, 5'd3, 32'hFFFF_FFFF));
    add_row(enc_u_lui(20'h80000, REG_A0), 1'b0, none);
    add_row(enc_r(F7_MULDIV, 5'd2, REG_A0, F3_DIV, 5'd4, OPC_OP), 1'b0, none);
    add_row(enc_r(F7_MULDIV, 5'd2, REG_A0, F3_REM, 5'd5, OPC_OP), 1'b0, none);
    add_row(enc_r(F7_MULDIV, 5'd0, 5'd1, F3_DIV, 5'd6, OPC_OP), 1'b0, none);
    add_row(enc_r(F7_MULDIV, 5'd0, 5'd1, F3_REM, 5'd7, OPC_OP), 1'b0, none);
    add_row(enc_r(F7_MULDIV, 5'd0, 5'd1, F3_REMU, 5'd8, OPC_OP), 1'b0, none);
    add_row(enc_r(F7_MULDIV, REG_A0, REG_A0, F3_MULH, 5'd9, OPC_OP), 1'b0, none);
    add_row(enc_r(F7_MULDIV, 5'd2, 5'd1, F3_MUL, 5'd11, OPC_OP), 1'b0, none);
    // Shift immediates with the ignored bit above the amount set.
    add_row(enc_i(12'h03F, 5'd2, F3_SLL, 5'd12, OPC_OPIMM), 1'b0, none);
    add_row(enc_i({F6_SRA, 6'h3F}, REG_A0, F3_SR, 5'd13, OPC_OPIMM), 1'b0, none);
    add_row(enc_i(12'h03F, 5'd2, F3_SR, 5'd14, OPC_OPIMM), 1'b0, none);
    add_row(enc_r(F7_ALT, 5'd2, REG_A0, F3_SR, 5'd15, OPC_OP), 1'b0, none);
    add_row(enc_r(F7_BASE, 5'd2, REG_A0, F3_SR, 5'd16, OPC_OP), 1'b0, none);
    add_row(enc_r(F7_ALT, 5'd2, 5'd0, F3_ADD, 5'd0, OPC_OP), 1'b0, none);
    add_row(enc_r(F7_BASE, 5'd1, REG_A0, F3_SLT, 5'd17, OPC_OP), 1'b0, none);
    add_row(enc_r(F7_BASE, 5'd1, REG_A0, F3_SLTU, 5'd18, OPC_OP), 1'b0, none);
    add_row(enc_r(F7_BASE, 5'd1, REG_A0, F3_XOR, 5'd19, OPC_OP), 1'b0, none);
    add_row(enc_r(F7_BASE, 5'd1, REG_A0, F3_OR, 5'd20, OPC_OP), 1'b0, none);
    add_row(enc_r(F7_BASE, 5'd1, REG_A0, F3_ADD, 5'd21, OPC_OP), 1'b0, none);
    add_row(enc_i(12'h800, 5'd1, F3_SLTU, 5'd22, OPC_OPIMM), 1'b0, none);
    add_row(enc_i(12'h7FF, 5'd2, F3_AND, 5'd23, OPC_OPIMM), 1'b0, none);
    add_row(enc_i(12'h800, 5'd2, F3_XOR, 5'd24, OPC_OPIMM), 1'b0, none);
    // Word accesses that wrap around the end of the data memory, then others.
    add_row(enc_s(12'hFFF, 5'd11, 5'd0, F3_SW), 1'b0, none);
    add_row(enc_i(12'hFFF, 5'd0, F3_LW, 5'd25, OPC_LOAD), 1'b0, none);
    add_row(enc_i(12'hFFE, 5'd0, F3_LH, 5'd26, OPC_LOAD), 1'b0, none);
    add_row(enc_s(12'h005, 5'd2, 5'd0, F3_SB), 1'b0, none);
    add_row(enc_i(12'h005, 5'd0, F3_LBU, 5'd27, OPC_LOAD), 1'b0, none);
    add_row({20'hFFFFF, 5'd28, OPC_AUIPC}, 1'b0, none);
    add_row(enc_j(21'h1FFFFE, 5'd1), 1'b0, none);
    add_row(enc_i(12'h7FF, 5'd0, 3'd0, 5'd29, OPC_JALR), 1'b0, none);
    add_row(enc_b(13'h1000, 5'd0, 5'd0, F3_BEQ), 1'b0, none);
    add_row(enc_b(13'h0FFE, 5'd1, 5'd2, F3_BNE), 1'b0, none);
    add_row(enc_b(13'h0010, 5'd2, REG_A0, F3_BLT), 1'b0, none);
    add_row(enc_b(13'h0020, REG_A0, 5'd2, F3_BGE), 1'b0, none);
    add_row(enc_b(13'h0040, 5'd2, 5'd1, F3_BLTU), 1'b0, none);
    add_row(enc_b(13'h1FF0, 5'd1, 5'd2, F3_BGEU), 1'b0, none);
  endtask

  function automatic logic [31:0] enc_u_lui(logic [19:0] imm, logic [4:0] rd);
    return {imm, rd, OPC_LUI};
  endfunction

  // Output stall: random except during the quiet stretch.
  always @(negedge clk_i) begin
    if (items_sent >= 700 && items_sent < 1000) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 25);
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10)
        $display("mismatch in %s at pc %h: expected %h, got %h", name,
                 want_res.exec_pc, want, got);
      mismatches++;
    end
  endtask

  // Result checking against the oldest outstanding expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid === 1'b1 && out_stall === 1'b0) begin
      got_res = dut_res;
      if (expected_q.size() == 0) begin
        if (mismatches < 10) $display("result with no item outstanding: %p", got_res);
        mismatches++;
      end else begin
        want_res = expected_q.pop_front();
        check_field("exec_pc", want_res.exec_pc, got_res.exec_pc);
        check_field("next_pc", want_res.next_pc, got_res.next_pc);
        check_field("dest_index", 32'(want_res.dest_index), 32'(got_res.dest_index));
        check_field("dest_value", want_res.dest_value, got_res.dest_value);
        check_field("dest_written", 32'(want_res.dest_written), 32'(got_res.dest_written));
        check_field("store_done", 32'(want_res.store_done), 32'(got_res.store_done));
        check_field("access_addr", want_res.access_addr, got_res.access_addr);
        check_field("status", 32'(want_res.status), 32'(got_res.status));
        check_field("halt_code", want_res.halt_code, got_res.halt_code);
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    logic [31:0] phase_pc [4];
    exec_res_t   none;
    logic [31:0] halt_insn;
    none = '0;
    mismatches = 0;
    cycle_cnt = 0;
    items_sent = 0;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    instruction = '0;
    out_stall = 1'b0;
    model_pc = START_PC_RST;
    model_halted = 1'b0;
    foreach (rf[i]) rf[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    build_table();
    write_start_pc(32'd0);
    foreach (dir_rows[i]) send_item(dir_rows[i].insn, dir_rows[i].typed, dir_rows[i].res);

    // Random programs over several start pc settings, the extremes among them.
    phase_pc[0] = 32'hFFFF_FFFF;
    phase_pc[1] = START_PC_RST;
    phase_pc[2] = $urandom;
    phase_pc[3] = 32'hFFFF_FFF0;
    for (int p = 0; p < 4; p++) begin
      write_start_pc(phase_pc[p]);
      repeat (RAND_PER_PHASE) send_item(rand_insn(), 1'b0, none);
    end

    // One halt, by ebreak or an invalid encoding, then items that are ignored.
    case ($urandom_range(0, 2))
      0: halt_insn = INSN_EBREAK;
      1: halt_insn = {25'd0, OPC_SYSTEM};
      default: halt_insn = enc_r(F7_BASE, 5'd1, 5'd2, F3_AND, 5'd3, OPC_OP);
    endcase
    send_item(halt_insn, 1'b0, none);
    repeat (4) send_item(rand_insn(), 1'b0, none);
    send_item(INSN_EBREAK, 1'b0, none);

    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
